// ===== rtl/tobc_pkg.sv =====
// tobc_pkg: shared types, codes and helpers of the timed output blink controller
// used by tobc_ctrl, tobc_dpath and timed_output_blink_controller_unit
package tobc_pkg;

    localparam int NUM_CHANNELS_DEF = 16;
    localparam int DIV_STEPS        = 3;    // settle cycles of the divide-by-100 pipeline
    localparam int DIV_CNT_W        = 2;
    localparam logic [6:0] PCT_FULL = 7'd100;

    // floor(y/25) = (y * RECIP_25) >> 34 for y below 2^29
    localparam logic [29:0] RECIP_25   = 30'd687194768;
    // floor(w/25) = (w * RECIP_25_S) >> 16 for w below 4096
    localparam logic [11:0] RECIP_25_S = 12'd2622;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_SET   = 2'd1;
    localparam logic [1:0] ACT_BLINK = 2'd2;

    localparam logic [2:0] MODE_ON     = 3'd0;
    localparam logic [2:0] MODE_OFF    = 3'd1;
    localparam logic [2:0] MODE_BH     = 3'd2;
    localparam logic [2:0] MODE_BL     = 3'd3;
    localparam logic [2:0] MODE_BLINK  = 3'd4;

    localparam logic [3:0] F_NONE  = 4'd0;
    localparam logic [3:0] F_ON    = 4'd1;
    localparam logic [3:0] F_OFF   = 4'd2;
    localparam logic [3:0] F_BH    = 4'd4;
    localparam logic [3:0] F_BL    = 4'd8;
    localparam logic [3:0] F_BLINK = 4'd12;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  channel;
        logic [2:0]  mode;
        logic [30:0] time_value;
        logic [7:0]  duty_percent;
        logic [15:0] pulse_count;
    } t_in_word;

    typedef struct packed {
        logic [15:0] pin_levels;
        logic [15:0] driven_mask;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic exec;
        logic div_start;
        logic div_step;
        logic apply;
        logic tick_step;
        logic tick_end;
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_tick;
        logic needs_div;
    } t_dp_sts;

    function automatic logic [3:0] mode_to_flags(input logic [2:0] mode);
        logic [3:0] f;
        case (mode)
            MODE_ON:    f = F_ON;
            MODE_OFF:   f = F_OFF;
            MODE_BH:    f = F_BH;
            MODE_BL:    f = F_BL;
            MODE_BLINK: f = F_BLINK;
            default:    f = F_NONE;
        endcase
        return f;
    endfunction

endpackage

// ===== rtl/tobc_ctrl.sv =====
// tobc_ctrl: sequencer of the blink controller (decode, divide, channel sweep)
// depends on tobc_pkg
module tobc_ctrl import tobc_pkg::*; #(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    output logic            o_done,
    input  t_dp_sts         i_sts,
    output t_ctrl_cmd       o_cmd,
    output logic [CH_W-1:0] o_idx
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_APPLY  = 3'd3;
    localparam logic [2:0] S_TICK   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    localparam logic [CH_W-1:0]      LAST_CH  = CH_W'(NUM_CHANNELS - 1);
    localparam logic [DIV_CNT_W-1:0] LAST_DIV = DIV_CNT_W'(DIV_STEPS - 1);

    logic [2:0]           r_state, n_state;
    logic [CH_W-1:0]      r_idx, n_idx;
    logic [DIV_CNT_W-1:0] r_dcnt, n_dcnt;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_dcnt  = r_dcnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_tick) begin
                    n_idx   = '0;
                    n_state = S_TICK;
                end else if (i_sts.needs_div) begin
                    o_cmd.div_start = 1'b1;
                    n_dcnt          = '0;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_dcnt         = r_dcnt + 1'b1;
                if (r_dcnt == LAST_DIV) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_DONE;
            end
            S_TICK: begin
                o_cmd.tick_step = 1'b1;
                n_idx           = r_idx + 1'b1;
                if (r_idx == LAST_CH) begin
                    o_cmd.tick_end = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_dcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_dcnt  <= n_dcnt;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_idx  = r_idx;

endmodule

// ===== rtl/tobc_dpath.sv =====
// tobc_dpath: channel records, tick clock, pin levels and the divide-by-100 unit
// depends on tobc_pkg
module tobc_dpath import tobc_pkg::*; #(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_in_word        i_word,
    input  t_ctrl_cmd       i_cmd,
    input  logic [CH_W-1:0] i_idx,
    output t_dp_sts         o_sts,
    output t_out_word       o_word
);

    logic [31:0]             r_clk;
    logic [3:0]              r_flags [NUM_CHANNELS];
    logic [31:0]             r_at    [NUM_CHANNELS];
    logic [30:0]             r_ht    [NUM_CHANNELS];
    logic [30:0]             r_lt    [NUM_CHANNELS];
    logic [15:0]             r_pl    [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_pin;
    logic [NUM_CHANNELS-1:0] r_mask;
    t_in_word                r_in;
    logic [24:0]             r_pq;    // floor(period / 100)
    logic [6:0]              r_pr;    // period mod 100
    logic [30:0]             r_pqd;   // floor(period / 100) * duty
    logic [13:0]             r_z;     // (period mod 100) * duty
    logic [30:0]             r_q;     // floor(period * duty / 100)
    logic                    r_rnz;   // remainder of period * duty / 100 nonzero

    logic [3:0]      c_f;
    logic            c_chan_ok;
    logic            c_valid;
    logic [CH_W-1:0] c_ch;
    logic [6:0]      c_duty;
    logic [58:0]     c_pq_prod;
    logic [30:0]     c_pq100;
    logic [23:0]     c_zq_prod;
    logic [7:0]      c_zq;
    logic [13:0]     c_z100;
    logic [30:0]     c_q;
    logic [30:0]     c_low;
    logic            c_degen;
    logic [3:0]      t_f;
    logic            t_hit;
    logic            t_forever;

    assign c_f       = mode_to_flags(r_in.mode);
    assign c_chan_ok = ({3'b000, r_in.channel} < 7'(NUM_CHANNELS));
    assign c_valid   = c_chan_ok && (c_f != F_NONE);
    assign c_ch      = CH_W'(r_in.channel);
    assign c_duty    = r_in.duty_percent[6:0];
    assign c_pq_prod = 59'(r_in.time_value[30:2]) * 59'(RECIP_25);
    assign c_pq100   = 31'(r_pq) * 31'd100;
    assign c_zq_prod = 24'(r_z[13:2]) * 24'(RECIP_25_S);
    assign c_zq      = c_zq_prod[23:16];
    assign c_z100    = 14'(c_zq) * 14'd100;
    assign c_q       = r_q;
    assign c_low     = r_in.time_value - c_q - {30'd0, r_rnz};
    assign c_degen   = (r_in.time_value < 31'd2) || (c_q == 31'd0) || (c_low == 31'd0);

    assign t_f       = r_flags[i_idx];
    assign t_hit     = (t_f != F_NONE) && (r_at[i_idx] == r_clk);
    assign t_forever = ((t_f & F_BLINK) == F_BLINK);

    assign o_sts.is_tick   = (r_in.action == ACT_TICK);
    assign o_sts.needs_div = (r_in.action == ACT_BLINK) && c_valid
                             && ((c_f & (F_ON | F_OFF)) == F_NONE)
                             && (r_in.duty_percent != 8'd0)
                             && (r_in.duty_percent < {1'b0, PCT_FULL});

    assign o_word.pin_levels  = 16'(r_pin);
    assign o_word.driven_mask = 16'(r_mask);

    // control state: clock, mode flags, pin levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk <= '0;
            r_pin <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_flags[i] <= F_NONE;
            end
        end else begin
            if (i_cmd.exec && c_valid
                && (r_in.action == ACT_SET || r_in.action == ACT_BLINK)) begin
                if ((c_f == F_ON || c_f == F_OFF)
                    && (r_in.action == ACT_SET || (c_f & (F_ON | F_OFF)) != F_NONE)) begin
                    if (r_in.time_value != 31'd0) begin
                        r_flags[c_ch] <= c_f;
                    end else begin
                        r_pin[c_ch]   <= (c_f == F_ON);
                        r_flags[c_ch] <= F_NONE;
                    end
                end else if (r_in.action == ACT_SET) begin
                    if (r_in.time_value > 31'd1) begin
                        r_flags[c_ch] <= c_f | F_ON;
                    end else begin
                        r_flags[c_ch] <= F_NONE;
                    end
                end else begin
                    // blink with duty zero drives low, duty full or more drives high
                    r_pin[c_ch]   <= (r_in.duty_percent != 8'd0);
                    r_flags[c_ch] <= F_NONE;
                end
            end
            if (i_cmd.apply) begin
                if (c_degen || r_in.pulse_count == 16'd0) begin
                    // blink forever carries the low flag as well, so it ends low
                    if ((c_f & F_BL) != F_NONE) begin
                        r_pin[c_ch] <= 1'b0;
                    end else if ((c_f & F_BH) != F_NONE) begin
                        r_pin[c_ch] <= 1'b1;
                    end
                    r_flags[c_ch] <= F_NONE;
                end else begin
                    r_flags[c_ch] <= c_f | F_ON;
                end
            end
            if (i_cmd.tick_step && t_hit) begin
                if ((t_f & F_BLINK) != F_NONE) begin
                    if ((t_f & F_ON) != F_NONE) begin
                        if (!t_forever && r_pl[i_idx] == 16'd0) begin
                            r_pin[i_idx]   <= ((t_f & F_BH) != F_NONE);
                            r_flags[i_idx] <= F_NONE;
                        end else begin
                            r_pin[i_idx]   <= 1'b1;
                            r_flags[i_idx] <= (t_f ^ F_ON) | F_OFF;
                        end
                    end else if ((t_f & F_OFF) != F_NONE) begin
                        r_pin[i_idx]   <= 1'b0;
                        r_flags[i_idx] <= (t_f ^ F_OFF) | F_ON;
                    end
                end else begin
                    r_pin[i_idx]   <= ((t_f & F_ON) != F_NONE);
                    r_flags[i_idx] <= F_NONE;
                end
            end
            if (i_cmd.tick_end) begin
                r_clk <= r_clk + 32'd1;
            end
        end
    end

    // payload: input word, channel records, mask, divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in   <= i_word;
            r_mask <= '0;
        end
        if (i_cmd.exec && c_valid
            && (r_in.action == ACT_SET || r_in.action == ACT_BLINK)) begin
            if ((c_f == F_ON || c_f == F_OFF)
                && (r_in.action == ACT_SET || (c_f & (F_ON | F_OFF)) != F_NONE)) begin
                if (r_in.time_value != 31'd0) begin
                    r_at[c_ch] <= r_clk + {1'b0, r_in.time_value};
                end else begin
                    r_mask[c_ch] <= 1'b1;
                end
            end else if (r_in.action == ACT_SET) begin
                if (r_in.time_value > 31'd1) begin
                    // 50 percent split is a plain halving of the period
                    r_at[c_ch] <= r_clk;
                    r_ht[c_ch] <= r_in.time_value >> 1;
                    r_lt[c_ch] <= r_in.time_value >> 1;
                    r_pl[c_ch] <= 16'd1;
                end
            end else begin
                r_mask[c_ch] <= 1'b1;
            end
        end
        // period split as 100*pq + pr, so period*duty/100 = pq*duty + pr*duty/100
        if (i_cmd.div_start) begin
            r_pq <= c_pq_prod[58:34];
        end
        // pipeline settles after three steps
        if (i_cmd.div_step) begin
            r_pr  <= 7'(r_in.time_value - c_pq100);
            r_pqd <= 31'(r_pq) * 31'(c_duty);
            r_z   <= 14'(r_pr) * 14'(c_duty);
            r_q   <= r_pqd + 31'(c_zq);
            r_rnz <= (r_z != c_z100);
        end
        if (i_cmd.apply) begin
            if (c_degen || r_in.pulse_count == 16'd0) begin
                r_mask[c_ch] <= 1'b1;
            end
            if (!c_degen) begin
                r_ht[c_ch] <= c_q;
                r_lt[c_ch] <= c_low;
                r_pl[c_ch] <= r_in.pulse_count;
                r_at[c_ch] <= r_clk;
            end
        end
        if (i_cmd.tick_step && t_hit) begin
            r_mask[i_idx] <= 1'b1;
            if ((t_f & F_BLINK) != F_NONE) begin
                if ((t_f & F_ON) != F_NONE) begin
                    r_at[i_idx] <= r_clk + {1'b0, r_ht[i_idx]};
                    if (!t_forever && r_pl[i_idx] != 16'd0) begin
                        r_pl[i_idx] <= r_pl[i_idx] - 16'd1;
                    end
                end else if ((t_f & F_OFF) != F_NONE) begin
                    r_at[i_idx] <= r_clk + {1'b0, r_lt[i_idx]};
                end
            end
        end
    end

endmodule

// ===== rtl/timed_output_blink_controller_unit.sv =====
// timed_output_blink_controller_unit: top level of the timed output blink controller
// depends on tobc_pkg, tobc_ctrl, tobc_dpath
//
//  channel   ports             handshake
//  command   i_cmd (t_in_word) word taken when start is high and busy is low
//  result    o_res (t_out_word) word valid for the one cycle o_done is high
//
// sequence: set command and plain blink go from decode straight to done,
//   blink with a pulse train adds a three-step reciprocal divide by 100
//   of period*duty and an apply step, tick sweeps one channel record per cycle
// busy stays high until the cycle after o_done; one word in flight at a time
// reset: synchronous active low; clock, mode flags and pin levels cleared
// the receiver cannot stall: o_res is shown for one cycle only
module timed_output_blink_controller_unit import tobc_pkg::*; #(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_cmd,
    output logic      o_done,
    output t_out_word o_res
);

    // channel index width, at least one bit
    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    t_ctrl_cmd       w_cmd;
    t_dp_sts         w_sts;
    logic [CH_W-1:0] w_idx;

    // sequencer: decode, divide and channel sweep
    tobc_ctrl #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .CH_W         (CH_W)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_idx   (w_idx)
    );

    // channel records, tick clock and pin levels
    tobc_dpath #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .CH_W         (CH_W)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (i_cmd),
        .i_cmd   (w_cmd),
        .i_idx   (w_idx),
        .o_sts   (w_sts),
        .o_word  (o_res)
    );

endmodule

// ===== verif/timed_output_blink_controller_unit_test.sv =====
// timed_output_blink_controller_unit_test: self-checking bench for the blink controller
// depends on tobc_pkg and timed_output_blink_controller_unit; predicts each result word
// and compares it with what the block returns
module timed_output_blink_controller_unit_test;
    import tobc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // scoreboard: a behavioral copy of the channel state and a queue of
    // predicted result words
    class blink_scoreboard;
        logic [31:0] clk_cnt;
        logic [3:0]  flags   [16];
        logic [31:0] act_time[16];
        logic [30:0] period  [16];
        logic [7:0]  duty    [16];
        logic [15:0] pulses  [16];
        logic [15:0] levels;
        logic [15:0] drv;
        t_out_word   pending[$];
        int          errors;

        function void clear();
            clk_cnt = '0;
            levels  = '0;
            errors  = 0;
            for (int i = 0; i < 16; i++) begin
                flags[i] = F_NONE;
                act_time[i] = '0;
                period[i] = '0;
                duty[i] = '0;
                pulses[i] = '0;
            end
            pending.delete();
        endfunction

        function void pin(int ch, bit hi);
            levels[ch] = hi;
            drv[ch]    = 1'b1;
        endfunction

        // floor(p * pct / 100) without overflow
        function logic [31:0] part(logic [30:0] p, int unsigned pct);
            logic [63:0] prod;
            prod = 64'(p) * 64'(pct);
            return 32'(prod / 64'd100);
        endfunction

        function void end_level(int ch, logic [3:0] f);
            if (f & F_BH) pin(ch, 1'b1);
            if (f & F_BL) pin(ch, 1'b0);
            flags[ch] = F_NONE;
        endfunction

        function void set_cmd(int ch, logic [3:0] f, logic [30:0] dly);
            if (f == F_ON || f == F_OFF) begin
                if (dly != 0) begin
                    act_time[ch] = clk_cnt + 32'(dly);
                    flags[ch] = f;
                end else begin
                    pin(ch, f == F_ON);
                    flags[ch] = F_NONE;
                end
            end else if (dly > 1) begin
                // simple one-pulse blink at half duty
                act_time[ch] = clk_cnt;
                period[ch] = dly;
                duty[ch] = 8'd50;
                pulses[ch] = 16'd1;
                flags[ch] = f | F_ON;
            end else begin
                flags[ch] = F_NONE;
            end
        endfunction

        function void blink_cmd(int ch, logic [3:0] f, logic [30:0] p, logic [7:0] d,
                                logic [15:0] n);
            if (f & (F_ON | F_OFF)) set_cmd(ch, f, p);
            else if (d == 0) set_cmd(ch, F_OFF, '0);
            else if (d >= 100) set_cmd(ch, F_ON, '0);
            else if (p < 2 || part(p, d) == 0 || part(p, 100 - d) == 0) end_level(ch, f);
            else begin
                period[ch] = p;
                duty[ch] = d;
                pulses[ch] = n;
                flags[ch] = f | F_ON;
                if (n == 0) end_level(ch, f);
                act_time[ch] = clk_cnt;
            end
        endfunction

        function void tick();
            logic [3:0] f;
            int unsigned d;
            for (int i = 0; i < 16; i++) begin
                f = flags[i];
                d = (duty[i] < 100) ? duty[i] : 99;
                if (f == F_NONE || act_time[i] != clk_cnt) continue;
                if (f & F_BLINK) begin
                    if (f & F_ON) begin
                        if ((f & F_BLINK) != F_BLINK && pulses[i] == 0) begin
                            pin(i, (f & F_BH) != 0);
                            f = F_NONE;
                        end else begin
                            pin(i, 1'b1);
                            if ((f & F_BLINK) != F_BLINK) pulses[i] = pulses[i] - 16'd1;
                            f = (f ^ F_ON) | F_OFF;
                        end
                        act_time[i] = clk_cnt + part(period[i], d);
                    end else if (f & F_OFF) begin
                        pin(i, 1'b0);
                        act_time[i] = clk_cnt + part(period[i], 100 - d);
                        f = (f ^ F_OFF) | F_ON;
                    end
                end else begin
                    if (f & F_ON) begin
                        pin(i, 1'b1);
                        f = F_NONE;
                    end
                    if (f & F_OFF) begin
                        pin(i, 1'b0);
                        f = F_NONE;
                    end
                end
                flags[i] = f;
            end
            clk_cnt++;
        endfunction

        function logic [3:0] mode_to_flags_tb(logic [2:0] m);
            case (m)
                MODE_ON:    return F_ON;
                MODE_OFF:   return F_OFF;
                MODE_BH:    return F_BH;
                MODE_BL:    return F_BL;
                MODE_BLINK: return F_BLINK;
                default:    return F_NONE;
            endcase
        endfunction

        // note an accepted command word and queue its predicted result
        function void note_cmd(t_in_word w);
            logic [3:0] f;
            t_out_word r;
            f = mode_to_flags_tb(w.mode);
            drv = '0;
            if (w.action == ACT_TICK) tick();
            else if ((w.action == ACT_SET || w.action == ACT_BLINK) && f != F_NONE) begin
                if (w.action == ACT_SET) set_cmd(w.channel, f, w.time_value);
                else blink_cmd(w.channel, f, w.time_value, w.duty_percent, w.pulse_count);
            end
            r.pin_levels = levels;
            r.driven_mask = drv;
            pending.push_back(r);
        endfunction

        // compare one result word with the oldest prediction
        function void check_res(t_out_word got);
            t_out_word exp_w;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %h", got);
                return;
            end
            exp_w = pending.pop_front();
            if (got.pin_levels !== exp_w.pin_levels || got.driven_mask !== exp_w.driven_mask) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: levels exp %h got %h, mask exp %h got %h",
                             exp_w.pin_levels, got.pin_levels,
                             exp_w.driven_mask, got.driven_mask);
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_word  i_cmd = '0;
    logic      o_done;
    t_out_word o_res;

    blink_scoreboard sb = new();
    int gap_left;   // sender gap counter, burst pattern

    timed_output_blink_controller_unit u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_cmd  (i_cmd),
        .o_done (o_done),
        .o_res  (o_res)
    );

    always #5 i_clk = ~i_clk;

    // accept side: commands at the rising edge, results on the strobe
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note_cmd(i_cmd);
            if (o_done) sb.check_res(o_res);
        end
    end

    // send one command word; start stays up across back-to-back words
    task automatic send_word(t_in_word w);
        if (gap_left > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap_left) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_cmd <= w;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // new burst or gap
        if ($urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 20);
        else gap_left = 0;
    endtask

    task automatic send_cmd(logic [1:0] act, logic [3:0] ch, logic [2:0] m,
                            logic [30:0] tv, logic [7:0] d, logic [15:0] n);
        t_in_word w;
        w.action = act;
        w.channel = ch;
        w.mode = m;
        w.time_value = tv;
        w.duty_percent = d;
        w.pulse_count = n;
        send_word(w);
    endtask

    task automatic send_ticks(int n);
        for (int i = 0; i < n; i++) send_cmd(ACT_TICK, 4'($urandom), 3'($urandom),
                                             31'($urandom), 8'($urandom), 16'($urandom));
    endtask

    // random command: mostly ticks and live blinks with short periods so trains run
    task automatic send_random();
        int pick;
        logic [30:0] tv;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0) tv = 31'($urandom);
        else tv = 31'($urandom_range(0, 12));
        if (pick < 50)
            send_ticks(1);
        else if (pick < 70)
            send_cmd(ACT_SET, 4'($urandom), 3'($urandom_range(0, 7)), tv,
                     8'($urandom), 16'($urandom));
        else if (pick < 95)
            send_cmd(ACT_BLINK, 4'($urandom), 3'($urandom_range(0, 7)),
                     31'($urandom_range(0, 20)),
                     ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 99)),
                     ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4)));
        else
            send_cmd(2'd3, 4'($urandom), 3'($urandom), tv, 8'($urandom), 16'($urandom));
    endtask

    initial begin
        #5000000;
        $display("FAIL timed_output_blink_controller_unit");
        $finish;
    end

    initial begin
        int waited;
        sb.clear();
        gap_left = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: plain levels, delays, extremes
        send_cmd(ACT_SET, 4'd0, MODE_ON, '0, '0, '0);
        send_cmd(ACT_SET, 4'd15, MODE_ON, '0, 8'hff, 16'hffff);
        send_cmd(ACT_SET, 4'd0, MODE_OFF, '0, '0, '0);
        send_cmd(ACT_SET, 4'd1, MODE_ON, 31'd2, '0, '0);
        send_cmd(ACT_SET, 4'd2, MODE_OFF, 31'h7fffffff, '0, '0);
        send_cmd(ACT_SET, 4'd3, MODE_BH, 31'd1, '0, '0);       // short simple blink: idle
        send_cmd(ACT_SET, 4'd4, MODE_BL, 31'd4, '0, '0);       // simple blink
        send_cmd(ACT_SET, 4'd5, 3'd7, '0, '0, '0);             // unused mode
        send_cmd(2'd3, 4'd5, MODE_ON, '0, '0, '0);             // unused action
        send_cmd(ACT_BLINK, 4'd6, MODE_ON, 31'd3, 8'd50, 16'd2);  // blink as set
        send_cmd(ACT_BLINK, 4'd7, MODE_BH, 31'd6, 8'd0, 16'd2);   // duty zero
        send_cmd(ACT_BLINK, 4'd8, MODE_BL, 31'd6, 8'd255, 16'd2); // duty full
        send_cmd(ACT_BLINK, 4'd9, MODE_BLINK, 31'd1, 8'd50, 16'd2); // short period
        send_cmd(ACT_BLINK, 4'd10, MODE_BH, 31'd10, 8'd1, 16'd2);   // zero high time
        send_cmd(ACT_BLINK, 4'd11, MODE_BL, 31'd6, 8'd50, 16'd0);   // zero pulses
        send_cmd(ACT_BLINK, 4'd12, MODE_BH, 31'd4, 8'd50, 16'd3);
        send_cmd(ACT_BLINK, 4'd13, MODE_BLINK, 31'd5, 8'd40, 16'd0);
        send_cmd(ACT_BLINK, 4'd14, MODE_BL, 31'h7fffffff, 8'd99, 16'hffff);
        send_ticks(7);

        for (int i = 0; i < 900; i++) send_random();

        @(negedge i_clk);
        start <= 1'b0;
        waited = 0;
        while (sb.pending.size() != 0 && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS timed_output_blink_controller_unit");
        else
            $display("FAIL timed_output_blink_controller_unit");
        $finish;
    end
endmodule
